FILE: design/i2c_timing_prescaler_search_defines.svh
// Assertion macros shared by the timing search checker.
`ifndef I2C_TIMING_PRESCALER_SEARCH_DEFINES_SVH
`define I2C_TIMING_PRESCALER_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define I2CTS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2cts: implication check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define I2CTS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2cts: next-cycle check failed");

`endif

FILE: design/i2cts_pkg.sv
// Types, constants and codes for the bus timing prescaler search.
`timescale 1ns / 1ps
package i2cts_pkg;

  localparam int unsigned PresetSlots  = 2;
  localparam int unsigned MaxPrescaler = 16;
  localparam int unsigned PreW         = $clog2(MaxPrescaler);

  localparam int unsigned ClkW     = 30;
  localparam int unsigned WordW    = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // shared divider: dividend and divisor both fit 30 bits
  localparam int unsigned DivW    = 30;
  localparam int unsigned DivCntW = $clog2(DivW);

  // minimum bus times in ns, all below 2^13
  localparam int unsigned TimeW = 13;
  localparam logic [DivW-1:0]  NsPerSecond = 30'd1000000000;
  localparam logic [TimeW-1:0] StdHighNs   = 13'd4000;
  localparam logic [TimeW-1:0] StdLowNs    = 13'd4700;
  localparam logic [TimeW-1:0] StdHoldNs   = 13'd500;
  localparam logic [TimeW-1:0] StdSetupNs  = 13'd1250;
  localparam logic [TimeW-1:0] FastHighNs  = 13'd600;
  localparam logic [TimeW-1:0] FastLowNs   = 13'd1300;
  localparam logic [TimeW-1:0] FastHoldNs  = 13'd375;
  localparam logic [TimeW-1:0] FastSetupNs = 13'd500;

  // field limits on the counts; SCL and setup counts have one taken off, hold does not
  localparam logic [TimeW-1:0] MaxSclCount   = 13'd256;
  localparam logic [TimeW-1:0] MaxHoldCount  = 13'd15;
  localparam logic [TimeW-1:0] MaxSetupCount = 13'd16;

  typedef enum logic [1:0] {
    SPEED_STD       = 2'd0,
    SPEED_FAST      = 2'd1,
    SPEED_FAST_PLUS = 2'd2,
    SPEED_HIGH      = 2'd3
  } speed_e;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_NEED_PRESET = 2'd1,
    STAT_NO_FIT      = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRESET_COUNT   = 3'd0,
    CFG_PRESET_A_SPEED = 3'd1,
    CFG_PRESET_A_CLOCK = 3'd2,
    CFG_PRESET_A_WORD  = 3'd3,
    CFG_PRESET_B_SPEED = 3'd4,
    CFG_PRESET_B_CLOCK = 3'd5,
    CFG_PRESET_B_WORD  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RES_PRESET,
    RES_OK,
    RES_NEED_PRESET,
    RES_NO_FIT
  } res_e;

  typedef enum logic [2:0] {
    OP_SCALED,
    OP_PERIOD,
    OP_HIGH,
    OP_LOW,
    OP_HOLD,
    OP_SETUP
  } div_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRESET,
    ST_LAUNCH,
    ST_WAIT,
    ST_TEST,
    ST_NEXT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [ClkW-1:0] clock_hz;
    logic [1:0]      speed_mode;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] timing_word;
    logic             from_preset;
    logic [1:0]       status;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    div_start;
    div_op_e div_op;
    logic    pre_step;
    logic    out_load;
    res_e    res;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic preset_hit;
    logic mode_ok;
    logic div_done;
    logic scaled_zero;
    logic period_zero;
    logic fits;
    logic pre_last;
    logic out_busy;
  } stat_t;

endpackage

FILE: design/i2cts_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module i2cts_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [i2cts_pkg::DivW-1:0] dividend_i,
  input  logic [i2cts_pkg::DivW-1:0] divisor_i,
  output logic                       done_o,
  output logic [i2cts_pkg::DivW-1:0] quotient_o
);
  import i2cts_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    rem_q, rem_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [DivW-1:0]    dvs_q, dvs_d;
  logic [DivW:0]      shifted;
  logic [DivW:0]      diff;
  logic               ge;
  logic               last;

  assign shifted = {rem_q, quo_q[DivW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign last    = cnt_q == DivCntW'(DivW - 1);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DivW-1:0] : shifted[DivW-1:0];
      quo_d = {quo_q[DivW-2:0], ge};
      cnt_d = cnt_q + DivCntW'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: design/i2cts_dp.sv
// Datapath: preset registers, operand select, shared divider, result register.
`timescale 1ns / 1ps
module i2cts_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  i2cts_pkg::in_t                in_data_i,
  output i2cts_pkg::out_t               out_data_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic                          cfg_we_i,
  input  logic [i2cts_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [i2cts_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  i2cts_pkg::ctrl_t              ctrl_i,
  output i2cts_pkg::stat_t              stat_o
);
  import i2cts_pkg::*;

  // configuration
  logic [1:0]       preset_count_q;
  logic [1:0]       preset_a_speed_q, preset_b_speed_q;
  logic [WordW-1:0] preset_a_clock_q, preset_b_clock_q;
  logic [WordW-1:0] preset_a_word_q,  preset_b_word_q;

  // item and search registers
  in_t              in_q;
  logic [PreW-1:0]  pre_q;
  logic [DivW-1:0]  scaled_q, period_q;
  logic [TimeW-1:0] high_q, low_q, hold_q, setup_q;

  out_t             out_q, out_d;
  logic             out_valid_q;

  logic             hit_a, hit_b;
  logic             std_mode;
  logic [TimeW-1:0] t_high, t_low, t_hold, t_setup;
  logic [DivW-1:0]  dividend, divisor;
  logic             div_done;
  logic [DivW-1:0]  quotient;
  logic [TimeW-1:0] high_m1, low_m1, setup_m1;
  logic [PreW-1:0]  pre_m1;
  logic [WordW-1:0] packed_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_count_q   <= '0;
      preset_a_speed_q <= '0;
      preset_a_clock_q <= '0;
      preset_a_word_q  <= '0;
      preset_b_speed_q <= '0;
      preset_b_clock_q <= '0;
      preset_b_word_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRESET_COUNT:   preset_count_q   <= cfg_wdata_i[1:0];
        CFG_PRESET_A_SPEED: preset_a_speed_q <= cfg_wdata_i[1:0];
        CFG_PRESET_A_CLOCK: preset_a_clock_q <= cfg_wdata_i;
        CFG_PRESET_A_WORD:  preset_a_word_q  <= cfg_wdata_i;
        CFG_PRESET_B_SPEED: preset_b_speed_q <= cfg_wdata_i[1:0];
        CFG_PRESET_B_CLOCK: preset_b_clock_q <= cfg_wdata_i;
        CFG_PRESET_B_WORD:  preset_b_word_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // entry A is in use for any nonzero count, entry B from two on
  assign hit_a = (preset_count_q != 2'd0) && (preset_a_speed_q == in_q.speed_mode) &&
                 (preset_a_clock_q == {2'b00, in_q.clock_hz});
  assign hit_b = (PresetSlots > 1) && (preset_count_q >= 2'd2) &&
                 (preset_b_speed_q == in_q.speed_mode) &&
                 (preset_b_clock_q == {2'b00, in_q.clock_hz});

  assign std_mode = in_q.speed_mode == SPEED_STD;
  assign t_high   = std_mode ? StdHighNs  : FastHighNs;
  assign t_low    = std_mode ? StdLowNs   : FastLowNs;
  assign t_hold   = std_mode ? StdHoldNs  : FastHoldNs;
  assign t_setup  = std_mode ? StdSetupNs : FastSetupNs;

  always_comb begin
    dividend = {{(DivW-TimeW){1'b0}}, t_high};
    divisor  = period_q;
    unique case (ctrl_i.div_op)
      OP_SCALED: begin
        dividend = in_q.clock_hz;
        divisor  = {{(DivW-PreW){1'b0}}, pre_q};
      end
      OP_PERIOD: begin
        dividend = NsPerSecond;
        divisor  = scaled_q;
      end
      OP_HIGH:  dividend = {{(DivW-TimeW){1'b0}}, t_high};
      OP_LOW:   dividend = {{(DivW-TimeW){1'b0}}, t_low};
      OP_HOLD:  dividend = {{(DivW-TimeW){1'b0}}, t_hold};
      OP_SETUP: dividend = {{(DivW-TimeW){1'b0}}, t_setup};
      default: ;
    endcase
  end

  i2cts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      in_q <= in_data_i;
    end
    if (div_done) begin
      unique case (ctrl_i.div_op)
        OP_SCALED: scaled_q <= quotient;
        OP_PERIOD: period_q <= quotient;
        OP_HIGH:   high_q   <= quotient[TimeW-1:0];
        OP_LOW:    low_q    <= quotient[TimeW-1:0];
        OP_HOLD:   hold_q   <= quotient[TimeW-1:0];
        OP_SETUP:  setup_q  <= quotient[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q <= PreW'(1);
    end else if (ctrl_i.load) begin
      pre_q <= PreW'(1);
    end else if (ctrl_i.pre_step) begin
      pre_q <= pre_q + PreW'(1);
    end
  end

  // count minus one, wraps on zero and then fails the range checks
  assign high_m1  = high_q - TimeW'(1);
  assign low_m1   = low_q - TimeW'(1);
  assign setup_m1 = setup_q - TimeW'(1);
  assign pre_m1   = pre_q - PreW'(1);

  assign packed_word = {pre_m1, 4'h0, setup_m1[3:0], hold_q[3:0],
                        high_m1[7:0], low_m1[7:0]};

  always_comb begin
    out_d = '0;
    unique case (ctrl_i.res)
      RES_PRESET: begin
        out_d.timing_word = hit_a ? preset_a_word_q : preset_b_word_q;
        out_d.from_preset = 1'b1;
        out_d.status      = STAT_OK;
      end
      RES_OK: begin
        out_d.timing_word = packed_word;
        out_d.status      = STAT_OK;
      end
      RES_NEED_PRESET: out_d.status = STAT_NEED_PRESET;
      RES_NO_FIT:      out_d.status = STAT_NO_FIT;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.preset_hit  = hit_a || hit_b;
  assign stat_o.mode_ok     = (in_q.speed_mode == SPEED_STD) ||
                              (in_q.speed_mode == SPEED_FAST);
  assign stat_o.div_done    = div_done;
  assign stat_o.scaled_zero = scaled_q == '0;
  assign stat_o.period_zero = period_q == '0;
  assign stat_o.fits        = (high_q != '0) && (high_q <= MaxSclCount) &&
                              (low_q != '0) && (low_q <= MaxSclCount) &&
                              (hold_q <= MaxHoldCount) &&
                              (setup_q != '0) && (setup_q <= MaxSetupCount);
  assign stat_o.pre_last    = pre_q == PreW'(MaxPrescaler - 1);
  assign stat_o.out_busy    = out_valid_q && !out_ready_i;

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

FILE: design/i2cts_ctrl.sv
// Controller: sequences preset check, divisions per prescaler and result load.
`timescale 1ns / 1ps
module i2cts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  i2cts_pkg::stat_t stat_i,
  output i2cts_pkg::ctrl_t ctrl_o
);
  import i2cts_pkg::*;

  state_e  state_q, state_d;
  div_op_e op_q, op_d;
  res_e    res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_SCALED;
      res_q   <= RES_NO_FIT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    res_d      = res_q;
    in_ready_o = 1'b0;
    ctrl_o     = '0;
    ctrl_o.div_op = op_q;
    ctrl_o.res    = res_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_PRESET;
        end
      end
      ST_PRESET: begin
        priority if (stat_i.preset_hit) begin
          res_d   = RES_PRESET;
          state_d = ST_FINISH;
        end else if (!stat_i.mode_ok) begin
          res_d   = RES_NEED_PRESET;
          state_d = ST_FINISH;
        end else begin
          op_d    = OP_SCALED;
          state_d = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        ctrl_o.div_start = 1'b1;
        state_d          = ST_WAIT;
      end
      ST_WAIT: begin
        if (stat_i.div_done) begin
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        state_d = ST_LAUNCH;
        unique case (op_q)
          OP_SCALED: begin
            if (stat_i.scaled_zero) state_d = ST_NEXT;
            else op_d = OP_PERIOD;
          end
          OP_PERIOD: begin
            if (stat_i.period_zero) state_d = ST_NEXT;
            else op_d = OP_HIGH;
          end
          OP_HIGH: op_d = OP_LOW;
          OP_LOW:  op_d = OP_HOLD;
          OP_HOLD: op_d = OP_SETUP;
          OP_SETUP: begin
            if (stat_i.fits) begin
              res_d   = RES_OK;
              state_d = ST_FINISH;
            end else begin
              state_d = ST_NEXT;
            end
          end
          default: state_d = ST_NEXT;
        endcase
      end
      ST_NEXT: begin
        if (stat_i.pre_last) begin
          res_d   = RES_NO_FIT;
          state_d = ST_FINISH;
        end else begin
          ctrl_o.pre_step = 1'b1;
          op_d            = OP_SCALED;
          state_d         = ST_LAUNCH;
        end
      end
      ST_FINISH: begin
        if (!stat_i.out_busy) begin
          ctrl_o.out_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: design/i2c_timing_prescaler_search.sv
// Top level: bus timing word search, controller plus datapath.
// Preset hit or unsupported speed: no division, the result is loaded from the finish state.
// Search: each division on the shared radix-2 divider runs launch, 30 quotient
// bits, done and test; a prescaler trial takes up to 6 of them plus 1 step,
// and a full sweep tries 15 prescalers. One item at a time.
// Reset: preset registers clear to zero, controller idles, output register empty.
`timescale 1ns / 1ps
module i2c_timing_prescaler_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input item channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  i2cts_pkg::in_t                in_data_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output i2cts_pkg::out_t               out_data_o,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [i2cts_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [i2cts_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import i2cts_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // Controller walks: preset check, then per prescaler clk/pre, 1e9/scaled,
  // and the four minimum times over the period, testing after each division.
  i2cts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // Datapath holds the item, the divider and the output register, so a
  // finished result may wait for its transfer while the next item is taken.
  i2cts_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

endmodule

FILE: design/i2cts_checker.sv
// Port-level checks for the timing search, bound to the top level.
`timescale 1ns / 1ps
`include "i2c_timing_prescaler_search_defines.svh"
module i2cts_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input i2cts_pkg::out_t                out_data_o
);
  import i2cts_pkg::*;

  logic res_fail;
  logic res_clear;
  logic res_known;

  assign res_fail  = out_valid_o && (out_data_o.status != STAT_OK);
  assign res_clear = (out_data_o.timing_word == '0) && !out_data_o.from_preset;
  assign res_known = (out_data_o.status == STAT_OK) ||
                     (out_data_o.status == STAT_NEED_PRESET) ||
                     (out_data_o.status == STAT_NO_FIT);

  `I2CTS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `I2CTS_ASSERT_NXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o)
  `I2CTS_ASSERT_IMP(a_fail_zero, res_fail, res_clear)
  `I2CTS_ASSERT_IMP(a_status_code, out_valid_o, res_known)

endmodule

bind i2c_timing_prescaler_search i2cts_checker u_i2cts_checker (.*);
